@@ src/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg: shared types, widths and helpers
// Fixed-point widths for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 18;

  // radicand magnitude width: covers three diagonal terms plus one
  localparam int RADU_W = ((FRAC_BITS + 1 > 19) ? FRAC_BITS + 1 : 19) + 1;
  localparam int RAD_W  = RADU_W + 1;
  localparam int NW     = RADU_W + FRAC_BITS;
  localparam int SQ_W   = NW + (NW % 2);
  localparam int R_W    = SQ_W / 2;
  localparam int NUM_W  = FIELD_W + 1;
  localparam int MAG_W  = FIELD_W + 1;
  localparam int DW     = MAG_W + FRAC_BITS;
  localparam int REM_W  = R_W + 2;
  localparam int LAT    = 2 + R_W + DW + 1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [DW-1:0] ONE_D   = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] POS_LIM = (DW'(1) << (FIELD_W - 1)) - DW'(1);
  localparam logic [DW-1:0] NEG_LIM = DW'(1) << (FIELD_W - 1);

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    logic                  bad;
    logic                  tbr;
    logic [1:0]            axis;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

  function automatic logic signed [RAD_W-1:0] sx(input field_t v);
    sx = {{(RAD_W - FIELD_W){v[FIELD_W-1]}}, v};
  endfunction

  // clamp to +/-1.0, then to the field range
  function automatic field_t sat_q(input logic [DW-1:0] mag, input logic neg);
    logic [DW-1:0] c;
    field_t        r;
    c = (mag > ONE_D) ? ONE_D : mag;
    if (!neg) begin
      r = (c > POS_LIM) ? POS_LIM[FIELD_W-1:0] : c[FIELD_W-1:0];
    end else if (c > NEG_LIM) begin
      r = NEG_LIM[FIELD_W-1:0];
    end else begin
      r = (~c[FIELD_W-1:0]) + field_t'(1);
    end
    sat_q = r;
  endfunction

endpackage

@@ src/rotation_matrix_to_quaternion_core.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core: 3x3 rotation matrix to quaternion
// Fully pipelined fixed-point conversion with a bad-radicand flag.
//
//   channel   direction  ports                           handshake
//   input     in         in_m00 .. in_m22                start / busy
//   result    out        out_quat_x/y/z/w, out_bad_input out_strobe
//
// One transaction enters per cycle; busy stays low.
// Pipeline: two decode stages, one square-root stage per root bit,
// one divider stage per quotient bit, one output register.
// Synchronous reset drops every transaction in flight.
// The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m00,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m01,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m02,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m10,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m11,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m12,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m20,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m21,
  input  logic [rmq_pkg::FIELD_W-1:0] in_m22,
  output logic                     out_strobe,
  output logic [rmq_pkg::FIELD_W-1:0] out_quat_x,
  output logic [rmq_pkg::FIELD_W-1:0] out_quat_y,
  output logic [rmq_pkg::FIELD_W-1:0] out_quat_z,
  output logic [rmq_pkg::FIELD_W-1:0] out_quat_w,
  output logic                     out_bad_input
);
  import rmq_pkg::*;

  logic [8:0][FIELD_W-1:0] m_in;
  logic                    f_vld, s_vld, d_vld;
  logic [SQ_W-1:0]         f_n;
  side_t                   f_side, s_side, d_side;
  logic [R_W-1:0]          s_root, d_root;
  logic [2:0][DW-1:0]      d_quo;
  logic [3:0][FIELD_W-1:0] q_res;

  assign busy = 1'b0;
  assign m_in = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  rmq_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start && !busy),
    .m_i    (m_in),
    .vld_o  (f_vld),
    .n_o    (f_n),
    .side_o (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (f_vld),
    .n_i    (f_n),
    .side_i (f_side),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (s_side)
  );

  rmq_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s_vld),
    .root_i (s_root),
    .side_i (s_side),
    .vld_o  (d_vld),
    .root_o (d_root),
    .quo_o  (d_quo),
    .side_o (d_side)
  );

  rmq_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (d_vld),
    .root_i (d_root),
    .quo_i  (d_quo),
    .side_i (d_side),
    .vld_o  (out_strobe),
    .q_o    (q_res),
    .bad_o  (out_bad_input)
  );

  assign out_quat_x = q_res[0];
  assign out_quat_y = q_res[1];
  assign out_quat_z = q_res[2];
  assign out_quat_w = q_res[3];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result strobe without a matching start");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_input) |->
      (out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0 && out_quat_w == '0))
    else $error("bad radicand with nonzero quaternion");

  a_trace_path: assert property (@(posedge clk) disable iff (!rst_n)
    (d_vld && d_side.tbr) |-> !d_side.bad)
    else $error("positive trace flagged as bad radicand");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !busy)
    else $error("busy raised");

endmodule

@@ src/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front: branch and axis decode
// Two stages: trace and axis pick, then radicand and the three numerators.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   vld_i,
  input  logic [8:0][rmq_pkg::FIELD_W-1:0]       m_i,
  output logic                                   vld_o,
  output logic [rmq_pkg::SQ_W-1:0]               n_o,
  output rmq_pkg::side_t                         side_o
);
  import rmq_pkg::*;

  logic                     vld1_r;
  logic [8:0][FIELD_W-1:0]  m1_r;
  logic                     tpos1_r;
  logic [1:0]               axis1_r;

  logic signed [RAD_W-1:0]  tr;
  logic                     tpos_nxt;
  logic [1:0]               axis_nxt;

  logic                     vld2_r;
  logic [SQ_W-1:0]          n2_r;
  side_t                    side2_r;

  logic signed [RAD_W-1:0]  mii, mjj, mkk, mkj, mjk, mji, mij, mki, mik;
  logic signed [RAD_W-1:0]  rad;
  logic signed [RAD_W-1:0]  num [3];
  logic [SQ_W-1:0]          n_nxt;
  side_t                    side_nxt;

  always_comb begin
    tr       = sx(m_i[0]) + sx(m_i[4]) + sx(m_i[8]);
    tpos_nxt = !tr[RAD_W-1] && (tr != '0);
    if ($signed(m_i[0]) < $signed(m_i[4])) begin
      axis_nxt = ($signed(m_i[4]) < $signed(m_i[8])) ? AXIS_Z : AXIS_Y;
    end else begin
      axis_nxt = ($signed(m_i[0]) < $signed(m_i[8])) ? AXIS_Z : AXIS_X;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
    m1_r    <= m_i;
    tpos1_r <= tpos_nxt;
    axis1_r <= axis_nxt;
  end

  always_comb begin
    unique case (axis1_r)
      AXIS_Y: begin
        mii = sx(m1_r[4]); mjj = sx(m1_r[8]); mkk = sx(m1_r[0]);
        mkj = sx(m1_r[2]); mjk = sx(m1_r[6]);
        mji = sx(m1_r[7]); mij = sx(m1_r[5]);
        mki = sx(m1_r[1]); mik = sx(m1_r[3]);
      end
      AXIS_Z: begin
        mii = sx(m1_r[8]); mjj = sx(m1_r[0]); mkk = sx(m1_r[4]);
        mkj = sx(m1_r[3]); mjk = sx(m1_r[1]);
        mji = sx(m1_r[2]); mij = sx(m1_r[6]);
        mki = sx(m1_r[5]); mik = sx(m1_r[7]);
      end
      default: begin
        mii = sx(m1_r[0]); mjj = sx(m1_r[4]); mkk = sx(m1_r[8]);
        mkj = sx(m1_r[7]); mjk = sx(m1_r[5]);
        mji = sx(m1_r[3]); mij = sx(m1_r[1]);
        mki = sx(m1_r[6]); mik = sx(m1_r[2]);
      end
    endcase

    if (tpos1_r) begin
      rad    = sx(m1_r[0]) + sx(m1_r[4]) + sx(m1_r[8]) + RAD_W'(ONE_D);
      num[0] = sx(m1_r[7]) - sx(m1_r[5]);
      num[1] = sx(m1_r[2]) - sx(m1_r[6]);
      num[2] = sx(m1_r[3]) - sx(m1_r[1]);
    end else begin
      rad    = mii - mjj - mkk + RAD_W'(ONE_D);
      num[0] = mkj - mjk;
      num[1] = mji + mij;
      num[2] = mki + mik;
    end

    n_nxt         = SQ_W'(rad[RADU_W-1:0]) << FRAC_BITS;
    side_nxt.bad  = !tpos1_r && (rad[RAD_W-1] || (rad == '0));
    side_nxt.tbr  = tpos1_r;
    side_nxt.axis = axis1_r;
    for (int l = 0; l < 3; l++) begin
      side_nxt.neg[l] = num[l][RAD_W-1];
      side_nxt.mag[l] = num[l][RAD_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    n2_r    <= n_nxt;
    side2_r <= side_nxt;
  end

  assign vld_o  = vld2_r;
  assign n_o    = n2_r;
  assign side_o = side2_r;

endmodule

@@ src/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// One root bit per stage, floor result; sideband travels alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic [rmq_pkg::SQ_W-1:0]  n_i,
  input  rmq_pkg::side_t            side_i,
  output logic                      vld_o,
  output logic [rmq_pkg::R_W-1:0]   root_o,
  output rmq_pkg::side_t            side_o
);
  import rmq_pkg::*;

  logic              vld_r  [R_W];
  logic [SQ_W-1:0]   n_r    [R_W];
  logic [REM_W-1:0]  rem_r  [R_W];
  logic [R_W-1:0]    root_r [R_W];
  side_t             side_r [R_W];

  for (genvar t = 0; t < R_W; t++) begin : g_stage
    logic              src_vld;
    logic [SQ_W-1:0]   src_n;
    logic [REM_W-1:0]  src_rem;
    logic [R_W-1:0]    src_root;
    side_t             src_side;
    logic [REM_W-1:0]  rem2, trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [R_W-1:0]    root_nxt;

    if (t == 0) begin : g_head
      assign src_vld  = vld_i;
      assign src_n    = n_i;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = side_i;
    end else begin : g_body
      assign src_vld  = vld_r[t-1];
      assign src_n    = n_r[t-1];
      assign src_rem  = rem_r[t-1];
      assign src_root = root_r[t-1];
      assign src_side = side_r[t-1];
    end

    always_comb begin
      rem2  = {src_rem[R_W-1:0], src_n[SQ_W-1 -: 2]};
      trial = {src_root, 2'b01};
      if (rem2 >= trial) begin
        rem_nxt  = rem2 - trial;
        root_nxt = {src_root[R_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2;
        root_nxt = {src_root[R_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[t] <= 1'b0;
      end else begin
        vld_r[t] <= src_vld;
      end
      n_r[t]    <= src_n << 2;
      rem_r[t]  <= rem_nxt;
      root_r[t] <= root_nxt;
      side_r[t] <= src_side;
    end
  end

  assign vld_o  = vld_r[R_W-1];
  assign root_o = root_r[R_W-1];
  assign side_o = side_r[R_W-1];

endmodule

@@ src/rmq_div.sv @@
// ----------------------------------------------------------------------------
// rmq_div: three-lane pipelined restoring divider
// Computes (mag << FRAC_BITS) / (2 * root) for each lane, one bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic [rmq_pkg::R_W-1:0]           root_i,
  input  rmq_pkg::side_t                    side_i,
  output logic                              vld_o,
  output logic [rmq_pkg::R_W-1:0]           root_o,
  output logic [2:0][rmq_pkg::DW-1:0]       quo_o,
  output rmq_pkg::side_t                    side_o
);
  import rmq_pkg::*;

  logic                   vld_r  [DW];
  logic [R_W-1:0]         root_r [DW];
  side_t                  side_r [DW];
  logic [2:0][DW-1:0]     dd_r   [DW];
  logic [2:0][REM_W-1:0]  rem_r  [DW];

  for (genvar t = 0; t < DW; t++) begin : g_stage
    logic                   src_vld;
    logic [R_W-1:0]         src_root;
    side_t                  src_side;
    logic [2:0][DW-1:0]     src_dd;
    logic [2:0][REM_W-1:0]  src_rem;
    logic [REM_W-1:0]       dvs;
    logic [REM_W-1:0]       rem2;
    logic [2:0][DW-1:0]     dd_nxt;
    logic [2:0][REM_W-1:0]  rem_nxt;

    if (t == 0) begin : g_head
      assign src_vld  = vld_i;
      assign src_root = root_i;
      assign src_side = side_i;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign src_dd[l]  = DW'(side_i.mag[l]) << FRAC_BITS;
        assign src_rem[l] = '0;
      end
    end else begin : g_body
      assign src_vld  = vld_r[t-1];
      assign src_root = root_r[t-1];
      assign src_side = side_r[t-1];
      assign src_dd   = dd_r[t-1];
      assign src_rem  = rem_r[t-1];
    end

    always_comb begin
      dvs = {1'b0, src_root, 1'b0};
      for (int l = 0; l < 3; l++) begin
        rem2 = {src_rem[l][REM_W-2:0], src_dd[l][DW-1]};
        if (rem2 >= dvs) begin
          rem_nxt[l] = rem2 - dvs;
          dd_nxt[l]  = {src_dd[l][DW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rem2;
          dd_nxt[l]  = {src_dd[l][DW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[t] <= 1'b0;
      end else begin
        vld_r[t] <= src_vld;
      end
      root_r[t] <= src_root;
      side_r[t] <= src_side;
      dd_r[t]   <= dd_nxt;
      rem_r[t]  <= rem_nxt;
    end
  end

  assign vld_o  = vld_r[DW-1];
  assign root_o = root_r[DW-1];
  assign quo_o  = dd_r[DW-1];
  assign side_o = side_r[DW-1];

endmodule

@@ src/rmq_out.sv @@
// ----------------------------------------------------------------------------
// rmq_out: saturation and component routing
// Places half the root and the quotients on x, y, z, w (all zero for a bad
// radicand) and registers the result.
module rmq_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [rmq_pkg::R_W-1:0]       root_i,
  input  logic [2:0][rmq_pkg::DW-1:0]   quo_i,
  input  rmq_pkg::side_t                side_i,
  output logic                          vld_o,
  output logic [3:0][rmq_pkg::FIELD_W-1:0] q_o,
  output logic                          bad_o
);
  import rmq_pkg::*;

  logic                    vld_r;
  logic [3:0][FIELD_W-1:0] q_r;
  logic                    bad_r;

  field_t                  hf, l0, l1, l2;
  logic [3:0][FIELD_W-1:0] q_nxt;

  always_comb begin
    hf = sat_q(DW'(root_i >> 1), 1'b0);
    l0 = sat_q(quo_i[0], side_i.neg[0]);
    l1 = sat_q(quo_i[1], side_i.neg[1]);
    l2 = sat_q(quo_i[2], side_i.neg[2]);
    // index 0..3 is x, y, z, w
    if (side_i.bad) begin
      q_nxt = '0;
    end else if (side_i.tbr) begin
      q_nxt = {hf, l2, l1, l0};
    end else begin
      unique case (side_i.axis)
        AXIS_Y:  q_nxt = {l0, l1, hf, l2};
        AXIS_Z:  q_nxt = {l0, hf, l2, l1};
        default: q_nxt = {l0, l2, l1, hf};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    q_r   <= q_nxt;
    bad_r <= side_i.bad;
  end

  assign vld_o = vld_r;
  assign q_o   = q_r;
  assign bad_o = bad_r;

endmodule

@@ bench/rotation_matrix_to_quaternion_core_test.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core_test: matrix to quaternion checker
// Drives 3x3 matrices through the start/busy port, predicts each quaternion
// with an independent fixed-point Shepperd computation and checks every
// strobed result in order, with random idle bursts on the input side.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmq_pkg::*;

  localparam longint ONE_FX   = longint'(1) << FRAC_BITS;
  localparam int     N_RANDOM = 1800;

  typedef struct {
    field_t m [9];
  } matrix_t;

  typedef struct {
    field_t q [4];   // x, y, z, w
    logic   bad;
  } quat_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  field_t in_m [9];
  logic   out_strobe;
  field_t out_quat_x, out_quat_y, out_quat_z, out_quat_w;
  logic   out_bad_input;

  matrix_t pending_mats [$];
  quat_t   expected_quats [$];
  int      errors = 0;
  int      n_checked = 0;
  int      n_pos_trace = 0;
  int      n_axis [3] = '{0, 0, 0};
  int      n_bad = 0;
  bit      stim_done = 1'b0;
  int      idle_left = 0;

  initial begin
    for (int f = 0; f < 9; f++) in_m[f] = '0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rotation_matrix_to_quaternion_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_m00       (in_m[0]),
    .in_m01       (in_m[1]),
    .in_m02       (in_m[2]),
    .in_m10       (in_m[3]),
    .in_m11       (in_m[4]),
    .in_m12       (in_m[5]),
    .in_m20       (in_m[6]),
    .in_m21       (in_m[7]),
    .in_m22       (in_m[8]),
    .out_strobe   (out_strobe),
    .out_quat_x   (out_quat_x),
    .out_quat_y   (out_quat_y),
    .out_quat_z   (out_quat_z),
    .out_quat_w   (out_quat_w),
    .out_bad_input(out_bad_input)
  );

  function automatic longint root_floor(longint n);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 60;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  // a / (2s) in fixed point, truncated toward zero
  function automatic longint half_ratio(longint a, longint s);
    longint mag;
    mag = (a < 0) ? -a : a;
    mag = (mag <<< FRAC_BITS) / (2 * s);
    return (a < 0) ? -mag : mag;
  endfunction

  function automatic field_t clamp_unit(longint v);
    if (v > ONE_FX) v = ONE_FX;
    if (v < -ONE_FX) v = -ONE_FX;
    return field_t'(v);
  endfunction

  function automatic quat_t quat_from_matrix(matrix_t mt);
    longint e [3][3];
    longint q [4];
    longint tr, rad, s;
    int     ax, jx, kx;
    quat_t  r;
    for (int f = 0; f < 9; f++) e[f / 3][f % 3] = longint'(signed'(mt.m[f]));
    q = '{0, 0, 0, 0};
    r.bad = 1'b0;
    tr = e[0][0] + e[1][1] + e[2][2];
    if (tr > 0) begin
      n_pos_trace++;
      s = root_floor((tr + ONE_FX) <<< FRAC_BITS);
      q[3] = s >>> 1;
      q[0] = half_ratio(e[2][1] - e[1][2], s);
      q[1] = half_ratio(e[0][2] - e[2][0], s);
      q[2] = half_ratio(e[1][0] - e[0][1], s);
    end else begin
      if (e[0][0] < e[1][1]) ax = (e[1][1] < e[2][2]) ? AXIS_Z : AXIS_Y;
      else                   ax = (e[0][0] < e[2][2]) ? AXIS_Z : AXIS_X;
      n_axis[ax]++;
      jx = (ax + 1) % 3;
      kx = (ax + 2) % 3;
      rad = e[ax][ax] - e[jx][jx] - e[kx][kx] + ONE_FX;
      if (rad <= 0) begin
        r.bad = 1'b1;
        n_bad++;
      end else begin
        s = root_floor(rad <<< FRAC_BITS);
        q[ax] = s >>> 1;
        q[3]  = half_ratio(e[kx][jx] - e[jx][kx], s);
        q[jx] = half_ratio(e[jx][ax] + e[ax][jx], s);
        q[kx] = half_ratio(e[kx][ax] + e[ax][kx], s);
      end
    end
    for (int c = 0; c < 4; c++) r.q[c] = clamp_unit(q[c]);
    return r;
  endfunction

  function automatic field_t rand_elem(int mode);
    case (mode)
      0:       return field_t'($urandom);
      1:       return field_t'($urandom_range(0, 2 * ONE_FX) - ONE_FX);
      default: return field_t'($urandom_range(0, ONE_FX / 4) - ONE_FX / 8);
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t mt;
    int      mode, dom;
    mode = $urandom_range(0, 9);
    for (int f = 0; f < 9; f++)
      mt.m[f] = rand_elem(mode < 2 ? 0 : (mode < 6 ? 1 : 2));
    // push one diagonal entry up to steer the axis choice
    if (mode >= 6) begin
      dom = $urandom_range(0, 2);
      for (int d = 0; d < 3; d++)
        mt.m[d * 4] = field_t'(-longint'($urandom_range(ONE_FX / 2, ONE_FX)));
      mt.m[dom * 4] = field_t'($urandom_range(0, 2 * ONE_FX) - ONE_FX);
    end
    return mt;
  endfunction

  function automatic matrix_t diag_matrix(longint a, longint b, longint c);
    matrix_t mt;
    for (int f = 0; f < 9; f++) mt.m[f] = '0;
    mt.m[0] = field_t'(a);
    mt.m[4] = field_t'(b);
    mt.m[8] = field_t'(c);
    return mt;
  endfunction

  // append one matrix to the pending queue
  task automatic add_mat(input matrix_t mt);
    pending_mats = {pending_mats, mt};
  endtask

  // stimulus
  initial begin
    matrix_t mt;
    add_mat(diag_matrix(ONE_FX, ONE_FX, ONE_FX));
    add_mat(diag_matrix(ONE_FX, -ONE_FX, -ONE_FX));
    add_mat(diag_matrix(-ONE_FX, ONE_FX, -ONE_FX));
    add_mat(diag_matrix(-ONE_FX, -ONE_FX, ONE_FX));
    add_mat(diag_matrix(0, 0, 0));
    add_mat(diag_matrix(-ONE_FX, -ONE_FX, -ONE_FX));
    add_mat(diag_matrix(131071, -65536, -65536));
    add_mat(diag_matrix(-131072, -131072, -131072));
    add_mat(diag_matrix(1, 0, -1));
    add_mat(diag_matrix(0, 0, 1));
    foreach (mt.m[f]) mt.m[f] = field_t'(17'h1ffff);
    add_mat(mt);
    foreach (mt.m[f]) mt.m[f] = field_t'(18'h20000);
    add_mat(mt);
    foreach (mt.m[f]) mt.m[f] = field_t'(ONE_FX);
    add_mat(mt);
    foreach (mt.m[f]) mt.m[f] = field_t'(-ONE_FX);
    add_mat(mt);
    foreach (mt.m[f]) mt.m[f] = (f % 2) ? field_t'(18'h2aaaa) : field_t'(18'h15555);
    add_mat(mt);
    foreach (mt.m[f]) mt.m[f] = (f % 2) ? field_t'(18'h15555) : field_t'(18'h2aaaa);
    add_mat(mt);
    // 90 degree turns about z and x, off-diagonal sign checks
    mt = diag_matrix(0, 0, ONE_FX);
    mt.m[1] = field_t'(-ONE_FX);
    mt.m[3] = field_t'(ONE_FX);
    add_mat(mt);
    mt = diag_matrix(ONE_FX, 0, 0);
    mt.m[5] = field_t'(ONE_FX);
    mt.m[7] = field_t'(-ONE_FX);
    add_mat(mt);
    for (int n = 0; n < N_RANDOM; n++) add_mat(random_matrix());
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    stim_done = 1'b1;
  end

  // driver: the item on the ports is taken at an edge with start high, busy low
  always @(posedge clk) begin
    quat_t   q_exp;
    matrix_t nx;
    if (rst_n) begin
      if (start && !busy) begin
        q_exp = quat_from_matrix('{m: in_m});
        expected_quats = {expected_quats, q_exp};
      end
      if (start && busy) begin
        start <= 1'b1;   // hold until taken
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_mats.size() > 200 && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 7);
        start <= 1'b0;
      end else if (pending_mats.size() > 0) begin
        nx = pending_mats.pop_front();
        in_m <= nx.m;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_t  q_exp;
    field_t got [4];
    if (rst_n && out_strobe) begin
      got = '{out_quat_x, out_quat_y, out_quat_z, out_quat_w};
      if (expected_quats.size() == 0) begin
        $display("%t: result with no transaction pending", $realtime);
        errors++;
      end else begin
        q_exp = expected_quats.pop_front();
        n_checked++;
        for (int c = 0; c < 4; c++)
          if (got[c] !== q_exp.q[c]) begin
            $display("%t: quat[%0d] expected %h actual %h", $realtime, c,
                     q_exp.q[c], got[c]);
            errors++;
          end
        if (out_bad_input !== q_exp.bad) begin
          $display("%t: bad_input expected %b actual %b", $realtime, q_exp.bad,
                   out_bad_input);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_mats.size() != 0 || start) @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    $display("checked %0d quaternions: %0d positive trace, axis x/y/z %0d/%0d/%0d",
             n_checked, n_pos_trace, n_axis[0], n_axis[1], n_axis[2]);
    $display("bad radicand cases: %0d, leftover expectations: %0d", n_bad,
             expected_quats.size());
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d items pending", pending_mats.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
